[rtl/tsol_pkg.sv]
// Package for the transpose self-organising list.
// Transaction types, status codes, register indexes and default sizes.
// No dependencies.
package tsol_pkg;

	localparam int DEPTH_DEFAULT      = 16;
	localparam int VALUE_BITS_DEFAULT = 8;

	localparam logic       OP_ACCESS = 1'b0;
	localparam logic       OP_READ   = 1'b1;

	localparam logic [2:0] ST_MOVED    = 3'd0;
	localparam logic [2:0] ST_FIRST    = 3'd1;
	localparam logic [2:0] ST_APPENDED = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_INVALID  = 3'd4;
	localparam logic [2:0] ST_READ     = 3'd5;
	localparam logic [2:0] ST_EMPTY    = 3'd6;

	localparam logic       REG_LOWEST  = 1'b0;
	localparam logic       REG_HIGHEST = 1'b1;

	localparam logic [7:0] LOWEST_RESET  = 8'd1;
	localparam logic [7:0] HIGHEST_RESET = 8'd100;

	typedef struct packed {
		logic       op;
		logic [7:0] value;
		logic [3:0] index;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] position;
		logic [7:0] value_out;
		logic [4:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic [7:0] lowest;
		logic [7:0] highest;
	} cfg_t;

	typedef struct packed {
		logic valid;
		rsp_t data;
	} res_t;

endpackage

[rtl/tsol_core.sv]
// Sequencer and list memory: linear search with one compare per cycle,
// transpose by two writes, append at the tail. Uses tsol_pkg.
module tsol_core #(
	parameter int DEPTH      = tsol_pkg::DEPTH_DEFAULT,
	parameter int VALUE_BITS = tsol_pkg::VALUE_BITS_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  tsol_pkg::req_t  req,
	input  tsol_pkg::cfg_t  cfg,
	input  logic            res_take,
	output logic            ready,
	output tsol_pkg::res_t  res
);

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > 4) ? CW : 4;
	localparam int VW   = VALUE_BITS;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SWAP,
		S_READ
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   fill_q;
	logic [AW-1:0]   ptr_q;
	logic [VW-1:0]   val_q;
	logic [VW-1:0]   prev_q;
	logic [3:0]      idx_q;
	logic [VW-1:0]   rdata_q;
	logic            res_v_q;
	tsol_pkg::rsp_t  res_q;

	logic [VW-1:0]   mem [DEPTH];

	logic [31:0]     val32;
	logic [VW-1:0]   val_m;
	logic            in_range;
	logic            full;
	logic            rd_ok;
	logic            hit;
	logic            last;
	logic [CW-1:0]   fill_inc;
	logic [CMPW-1:0] idx_w;
	logic [CMPW-1:0] fill_w;
	logic            we;
	logic [AW-1:0]   waddr;
	logic [VW-1:0]   wdata;
	logic [AW-1:0]   raddr;

	function automatic logic [3:0] pos4(input logic [CW-1:0] p);
		logic [31:0] t;
		t = 32'(p);
		return t[3:0];
	endfunction

	function automatic logic [4:0] cnt5(input logic [CW-1:0] c);
		logic [31:0] t;
		t = 32'(c);
		return t[4:0];
	endfunction

	function automatic logic [7:0] val8(input logic [VW-1:0] v);
		logic [31:0] t;
		t = 32'(v);
		return t[7:0];
	endfunction

	assign val32    = 32'(req.value);
	assign val_m    = val32[VW-1:0];
	assign in_range = (32'(val_m) >= 32'(cfg.lowest)) && (32'(val_m) <= 32'(cfg.highest));
	assign full     = (fill_q == CW'(DEPTH));
	assign idx_w    = CMPW'(req.index);
	assign fill_w   = CMPW'(fill_q);
	assign rd_ok    = (idx_w < fill_w);
	assign hit      = (rdata_q == val_q);
	assign last     = (CW'(ptr_q) == fill_q - CW'(1));
	assign fill_inc = fill_q + CW'(1);

	assign ready = (state_q == S_IDLE) && !res_v_q;
	assign res   = '{valid: res_v_q, data: res_q};

	always_comb begin
		we    = 1'b0;
		waddr = ptr_q;
		wdata = prev_q;
		raddr = ptr_q + AW'(1);
		unique case (state_q)
			S_IDLE: begin
				if (req.op == tsol_pkg::OP_READ) begin
					raddr = AW'(req.index);
				end else begin
					raddr = '0;
					if (start && in_range && (fill_q == '0)) begin
						we    = 1'b1;
						waddr = '0;
						wdata = val_m;
					end
				end
			end
			S_SCAN: begin
				if (hit && (ptr_q != '0)) begin
					we = 1'b1;
				end else if (!hit && last) begin
					we    = 1'b1;
					waddr = AW'(fill_q);
					wdata = val_q;
				end
			end
			S_SWAP: begin
				we    = 1'b1;
				waddr = ptr_q - AW'(1);
				wdata = val_q;
			end
			S_READ: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			res_v_q <= 1'b0;
		end else begin
			if (res_take) begin
				res_v_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						val_q <= val_m;
						idx_q <= req.index;
						ptr_q <= '0;
						if (req.op == tsol_pkg::OP_READ) begin
							if (rd_ok) begin
								state_q <= S_READ;
							end else begin
								res_q   <= '{tsol_pkg::ST_EMPTY, req.index, 8'd0,
									cnt5(fill_q)};
								res_v_q <= 1'b1;
							end
						end else if (!in_range) begin
							res_q   <= '{tsol_pkg::ST_INVALID, 4'd0, val8(val_m),
								cnt5(fill_q)};
							res_v_q <= 1'b1;
						end else if (full) begin
							res_q   <= '{tsol_pkg::ST_FULL, 4'd0, val8(val_m),
								cnt5(fill_q)};
							res_v_q <= 1'b1;
						end else if (fill_q == '0) begin
							fill_q  <= fill_inc;
							res_q   <= '{tsol_pkg::ST_APPENDED, 4'd0, val8(val_m),
								cnt5(fill_inc)};
							res_v_q <= 1'b1;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					prev_q <= rdata_q;
					if (hit) begin
						if (ptr_q == '0) begin
							res_q   <= '{tsol_pkg::ST_FIRST, 4'd0, val8(val_q),
								cnt5(fill_q)};
							res_v_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_SWAP;
						end
					end else if (last) begin
						fill_q  <= fill_inc;
						res_q   <= '{tsol_pkg::ST_APPENDED, pos4(fill_q), val8(val_q),
							cnt5(fill_inc)};
						res_v_q <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				S_SWAP: begin
					res_q   <= '{tsol_pkg::ST_MOVED, pos4(CW'(ptr_q - AW'(1))),
						val8(val_q), cnt5(fill_q)};
					res_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				S_READ: begin
					res_q   <= '{tsol_pkg::ST_READ, idx_q, val8(rdata_q), cnt5(fill_q)};
					res_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/transpose_self_organizing_list.sv]
// Top level of the transpose self-organising list: configuration registers,
// output register and the tsol_core sequencer. Uses tsol_pkg.
//
//   channel  direction  handshake                payload
//   req      in         req_valid / req_stall    tsol_pkg::req_t
//   rsp      out        rsp_valid / rsp_stall    tsol_pkg::rsp_t
//   cfg      in         cfg_we                   cfg_index, cfg_data
//
// An access that is out of range, refused as full or lands in an empty list
// is answered straight from the idle state, as is a read past the fill; a read
// of a stored entry passes the read state. A search compares one stored entry
// per cycle from the head until a hit or the tail; a hit past the head then
// passes the swap state for the transpose. Each result then passes the output
// register, which lets the next transaction in while it waits.
// Reset empties the list and loads lowest 1, highest 100; no clearing pass.
module transpose_self_organizing_list #(
	parameter int DEPTH      = tsol_pkg::DEPTH_DEFAULT,
	parameter int VALUE_BITS = tsol_pkg::VALUE_BITS_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  tsol_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output tsol_pkg::rsp_t rsp,
	input  logic           cfg_we,
	input  logic           cfg_index,
	input  logic [7:0]     cfg_data
);

	tsol_pkg::cfg_t cfg_q;
	tsol_pkg::res_t res;
	tsol_pkg::rsp_t rsp_q;
	logic           rsp_valid_q;
	logic           core_ready;
	logic           start;
	logic           res_take;

	assign req_stall = !core_ready;
	assign start     = req_valid && core_ready;
	assign res_take  = res.valid && (!rsp_valid_q || !rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lowest  <= tsol_pkg::LOWEST_RESET;
			cfg_q.highest <= tsol_pkg::HIGHEST_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tsol_pkg::REG_LOWEST:  cfg_q.lowest  <= cfg_data;
				tsol_pkg::REG_HIGHEST: cfg_q.highest <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_take) begin
			rsp_valid_q <= 1'b1;
			rsp_q       <= res.data;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	tsol_core #(
		.DEPTH      (DEPTH),
		.VALUE_BITS (VALUE_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req),
		.cfg      (cfg_q),
		.res_take (res_take),
		.ready    (core_ready),
		.res      (res)
	);

endmodule
